// ===== sv/vector_normalize_unit_assert.svh =====
// Assertion shorthands for the vector normalize unit
`ifndef VECTOR_NORMALIZE_UNIT_ASSERT_SVH
`define VECTOR_NORMALIZE_UNIT_ASSERT_SVH
`define VNU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define VNU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);
`endif

// ===== sv/vnu_pkg.sv =====
package vnu_pkg;
  localparam int COMP_W = 32;
  localparam int MAG_W  = 32;
  localparam int SUM_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 35;
  localparam int UNIT_W = 18;
  localparam int NLANE  = 3;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } comp_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    comp_t            x;
    comp_t            y;
    comp_t            z;
    logic             point;
  } item_t;
endpackage

// ===== sv/vnu_front.sv =====
module vnu_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       start_i,
  input  logic [vnu_pkg::COMP_W-1:0] vec_x_i,
  input  logic [vnu_pkg::COMP_W-1:0] vec_y_i,
  input  logic [vnu_pkg::COMP_W-1:0] vec_z_i,
  input  logic                       point_flag_i,
  output logic                       valid_o,
  output vnu_pkg::item_t             item_o
);
  function automatic vnu_pkg::comp_t abs_comp(input logic [vnu_pkg::COMP_W-1:0] v);
    vnu_pkg::comp_t c;
    c.neg = v[vnu_pkg::COMP_W-1];
    c.mag = c.neg ? (~v + 1'b1) : v;
    return c;
  endfunction

  logic v1_q, v2_q, v3_q;
  vnu_pkg::comp_t x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;
  logic p1_q, p2_q;
  logic [vnu_pkg::SUM_W-1:0] sqx_q, sqy_q, sqz_q;
  vnu_pkg::item_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= abs_comp(vec_x_i);
      y1_q  <= abs_comp(vec_y_i);
      z1_q  <= abs_comp(vec_z_i);
      p1_q  <= point_flag_i;
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      z2_q  <= z1_q;
      p2_q  <= p1_q;
      sqx_q <= x1_q.mag * x1_q.mag;
      sqy_q <= y1_q.mag * y1_q.mag;
      sqz_q <= z1_q.mag * z1_q.mag;
      item_q.sum   <= sqx_q + sqy_q + sqz_q;
      item_q.x     <= x2_q;
      item_q.y     <= y2_q;
      item_q.z     <= z2_q;
      item_q.point <= p2_q;
    end
  end

  assign valid_o = v3_q;
  assign item_o  = item_q;
endmodule

// ===== sv/vnu_queue.sv =====
module vnu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vnu_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output vnu_pkg::item_t item_o
);
  vnu_pkg::item_t slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= item_i;
  end
endmodule

// ===== sv/vnu_back.sv =====
module vnu_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  vnu_pkg::item_t             item_i,
  output logic                       valid_o,
  output logic [vnu_pkg::UNIT_W-1:0] unit_x_o,
  output logic [vnu_pkg::UNIT_W-1:0] unit_y_o,
  output logic [vnu_pkg::UNIT_W-1:0] unit_z_o,
  output logic                       unit_point_flag_o,
  output logic [vnu_pkg::ROOT_W-1:0] length_o
);
  localparam int QW    = FRAC_BITS + 1;
  localparam int NSQ   = vnu_pkg::ROOT_W;
  localparam int EXT_W = QW + vnu_pkg::UNIT_W;
  localparam int RW    = vnu_pkg::REM_W;
  localparam int MW    = vnu_pkg::MAG_W;
  localparam int LW    = vnu_pkg::ROOT_W;

  logic           sv_q    [1:NSQ];
  vnu_pkg::item_t sit_q   [1:NSQ];
  logic [RW-1:0]  srem_q  [1:NSQ];
  logic [LW-1:0]  sroot_q [1:NSQ];

  for (genvar s = 0; s < NSQ; s++) begin : g_sqrt
    localparam int I = NSQ - 1 - s;
    logic           v_in;
    vnu_pkg::item_t it_in;
    logic [RW-1:0]  rem_in, cur, trial;
    logic [LW-1:0]  root_in;
    logic           ge;
    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign it_in   = item_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign v_in    = sv_q[s];
      assign it_in   = sit_q[s];
      assign rem_in  = srem_q[s];
      assign root_in = sroot_q[s];
    end
    assign cur   = {rem_in[RW-3:0], it_in.sum[2*I+1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[s+1] <= 1'b0;
      end else begin
        sv_q[s+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sit_q[s+1]   <= it_in;
      srem_q[s+1]  <= ge ? (cur - trial) : cur;
      sroot_q[s+1] <= {root_in[LW-2:0], ge};
    end
  end

  logic          dv_q   [1:QW];
  logic [LW-1:0] dlen_q [1:QW];
  logic [MW-1:0] dr_q   [1:QW][vnu_pkg::NLANE];
  logic [QW-1:0] dqt_q  [1:QW][vnu_pkg::NLANE];
  logic [2:0]    dneg_q [1:QW];
  logic          dpt_q  [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic          v_in, p_in;
    logic [LW-1:0] l_in;
    logic [2:0]    n_in;
    logic [MW-1:0] r_in [vnu_pkg::NLANE];
    logic [QW-1:0] q_in [vnu_pkg::NLANE];
    logic [MW:0]   t    [vnu_pkg::NLANE];
    logic [MW:0]   diff [vnu_pkg::NLANE];
    logic [MW-1:0] r_n  [vnu_pkg::NLANE];
    logic [QW-1:0] q_n  [vnu_pkg::NLANE];
    if (k == 0) begin : g_first
      assign v_in    = sv_q[NSQ];
      assign l_in    = sroot_q[NSQ];
      assign p_in    = sit_q[NSQ].point;
      assign n_in    = {sit_q[NSQ].z.neg, sit_q[NSQ].y.neg, sit_q[NSQ].x.neg};
      assign r_in[0] = sit_q[NSQ].x.mag;
      assign r_in[1] = sit_q[NSQ].y.mag;
      assign r_in[2] = sit_q[NSQ].z.mag;
      assign q_in[0] = '0;
      assign q_in[1] = '0;
      assign q_in[2] = '0;
    end else begin : g_rest
      assign v_in = dv_q[k];
      assign l_in = dlen_q[k];
      assign p_in = dpt_q[k];
      assign n_in = dneg_q[k];
      assign r_in = dr_q[k];
      assign q_in = dqt_q[k];
    end

    always_comb begin
      for (int l = 0; l < vnu_pkg::NLANE; l++) begin
        t[l]    = (k == 0) ? {1'b0, r_in[l]} : {r_in[l], 1'b0};
        diff[l] = t[l] - {1'b0, l_in};
        if (t[l] >= {1'b0, l_in}) begin
          r_n[l] = diff[l][MW-1:0];
          q_n[l] = {q_in[l][QW-2:0], 1'b1};
        end else begin
          r_n[l] = t[l][MW-1:0];
          q_n[l] = {q_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dlen_q[k+1] <= l_in;
      dneg_q[k+1] <= n_in;
      dpt_q[k+1]  <= p_in;
      dr_q[k+1]   <= r_n;
      dqt_q[k+1]  <= q_n;
    end
  end

  logic                       zero;
  logic [EXT_W-1:0]           ext  [vnu_pkg::NLANE];
  logic [EXT_W-1:0]           sgn  [vnu_pkg::NLANE];
  logic [vnu_pkg::UNIT_W-1:0] unit [vnu_pkg::NLANE];
  logic                       ov_q;
  logic [vnu_pkg::UNIT_W-1:0] ux_q, uy_q, uz_q;
  logic                       up_q;
  logic [LW-1:0]              len_q;

  assign zero = (dlen_q[QW] == '0);

  always_comb begin
    for (int l = 0; l < vnu_pkg::NLANE; l++) begin
      ext[l]  = {{vnu_pkg::UNIT_W{1'b0}}, dqt_q[QW][l]};
      sgn[l]  = dneg_q[QW][l] ? (~ext[l] + 1'b1) : ext[l];
      unit[l] = zero ? '0 : sgn[l][vnu_pkg::UNIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    ux_q  <= unit[0];
    uy_q  <= unit[1];
    uz_q  <= unit[2];
    up_q  <= zero | dpt_q[QW];
    len_q <= dlen_q[QW];
  end

  assign valid_o           = ov_q;
  assign unit_x_o          = ux_q;
  assign unit_y_o          = uy_q;
  assign unit_z_o          = uz_q;
  assign unit_point_flag_o = up_q;
  assign length_o          = len_q;
endmodule

// ===== sv/vector_normalize_unit.sv =====
// channel  | direction | handshake                     | payload
// ---------+-----------+-------------------------------+-------------------------------------
// command  | in        | start, busy                   | vec_x_i, vec_y_i, vec_z_i, point_flag_i
// result   | out       | result_valid_o (one-cycle)    | unit_x_o, unit_y_o, unit_z_o,
//          |           |                               | unit_point_flag_o, length_o
//
// One vector per cycle while busy is low, fully pipelined; a result passes the front end, the queue,
// the 32-stage root pipeline, FRAC_BITS + 1 divide stages and an output register.
// Reset clears all valid bits and the queue; no clearing pass.
// The result side has no backpressure, so the back end drains every cycle and busy stays low.
module vector_normalize_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [vnu_pkg::COMP_W-1:0] vec_x_i,
  input  logic [vnu_pkg::COMP_W-1:0] vec_y_i,
  input  logic [vnu_pkg::COMP_W-1:0] vec_z_i,
  input  logic                       point_flag_i,
  output logic                       result_valid_o,
  output logic [vnu_pkg::UNIT_W-1:0] unit_x_o,
  output logic [vnu_pkg::UNIT_W-1:0] unit_y_o,
  output logic [vnu_pkg::UNIT_W-1:0] unit_z_o,
  output logic                       unit_point_flag_o,
  output logic [vnu_pkg::ROOT_W-1:0] length_o
);
  logic           f_valid, q_full, q_valid;
  vnu_pkg::item_t f_item, q_item;

  assign busy = q_full;

  vnu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (!q_full),
    .start_i      (start),
    .vec_x_i      (vec_x_i),
    .vec_y_i      (vec_y_i),
    .vec_z_i      (vec_z_i),
    .point_flag_i (point_flag_i),
    .valid_o      (f_valid),
    .item_o       (f_item)
  );

  vnu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .item_i  (f_item),
    .pop_i   (q_valid),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  vnu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (q_valid),
    .item_i            (q_item),
    .valid_o           (result_valid_o),
    .unit_x_o          (unit_x_o),
    .unit_y_o          (unit_y_o),
    .unit_z_o          (unit_z_o),
    .unit_point_flag_o (unit_point_flag_o),
    .length_o          (length_o)
  );
endmodule

// ===== sv/vnu_checker.sv =====
`include "vector_normalize_unit_assert.svh"

module vnu_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       busy,
  input logic                       result_valid_o,
  input logic [vnu_pkg::UNIT_W-1:0] unit_x_o,
  input logic [vnu_pkg::UNIT_W-1:0] unit_y_o,
  input logic [vnu_pkg::UNIT_W-1:0] unit_z_o,
  input logic                       unit_point_flag_o,
  input logic [vnu_pkg::ROOT_W-1:0] length_o
);
  localparam logic [vnu_pkg::UNIT_W-1:0] MOST_NEG = {1'b1, {(vnu_pkg::UNIT_W-1){1'b0}}};

  `VNU_ASSERT_IMP(a_zero_len, clk_i, rst_ni, result_valid_o && length_o == '0, unit_point_flag_o && unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0, "zero length result not cleared")
  `VNU_ASSERT_NEVER(a_no_busy, clk_i, rst_ni, busy, "queue filled although back end drains")
  `VNU_ASSERT_IMP(a_unit_range, clk_i, rst_ni, result_valid_o, unit_x_o != MOST_NEG && unit_y_o != MOST_NEG && unit_z_o != MOST_NEG, "unit component out of range")
endmodule

bind vector_normalize_unit vnu_checker u_vnu_checker (.*);
